[design/priority_run_queue_macros.svh]
`ifndef PRIORITY_RUN_QUEUE_MACROS_SVH
`define PRIORITY_RUN_QUEUE_MACROS_SVH

// same-cycle implication, masked during reset
`define PRQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority_run_queue: same-cycle check failed");

// next-cycle implication, masked during reset
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority_run_queue: next-cycle check failed");

`endif

[design/prq_pkg.sv]
package prq_pkg;

  localparam int unsigned ID_W    = 15;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned SLICE_W = 8;
  localparam int unsigned COUNT_W = 6;

  localparam logic [PRIO_W-1:0]  DEFAULT_PRIORITY = 8'd10;
  localparam logic [SLICE_W-1:0] MAX_SLICE_RESET  = 8'd5;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_PICK    = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_FULL   = 2'd1,
    FAULT_ABSENT = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [SLICE_W-1:0] slice;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_last;
  } ctrl_stat_t;

endpackage

[design/prq_ram.sv]
module prq_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/prq_ctrl.sv]
module prq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [1:0]             cmd,
  input  prq_pkg::ctrl_stat_t    stat,
  output prq_pkg::ctrl_cmd_t     ctl,
  output logic                   busy
);

  prq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      prq_pkg::ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          if (prq_pkg::cmd_t'(cmd) == prq_pkg::CMD_TICK) begin
            state_next = prq_pkg::ST_DONE;
          end else begin
            state_next = prq_pkg::ST_SCAN;
          end
        end
      end
      prq_pkg::ST_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.idx_last) begin
          state_next = prq_pkg::ST_FLUSH;
        end
      end
      prq_pkg::ST_FLUSH: begin
        state_next = prq_pkg::ST_DONE;
      end
      prq_pkg::ST_DONE: begin
        ctl.commit = 1'b1;
        state_next = prq_pkg::ST_IDLE;
      end
      default: begin
        state_next = prq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != prq_pkg::ST_IDLE);

endmodule

[design/prq_datapath.sv]
module prq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  prq_pkg::ctrl_cmd_t            ctl,
  output prq_pkg::ctrl_stat_t           stat,
  input  logic [1:0]                    cmd,
  input  logic [prq_pkg::ID_W-1:0]      task_id,
  input  logic [prq_pkg::PRIO_W-1:0]    task_priority,
  input  logic [prq_pkg::SLICE_W-1:0]   task_slice,
  input  logic                          cfg_we,
  input  logic [prq_pkg::SLICE_W-1:0]   cfg_data,
  output logic                          done,
  output logic                          found,
  output logic [prq_pkg::ID_W-1:0]      picked_id,
  output logic [prq_pkg::PRIO_W-1:0]    picked_priority,
  output logic [prq_pkg::SLICE_W-1:0]   granted_slice,
  output logic                          resched,
  output logic [prq_pkg::COUNT_W-1:0]   queued_count,
  output logic [1:0]                    fault
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = $bits(prq_pkg::entry_t);

  logic [QUEUE_DEPTH-1:0]          slot_valid;
  logic [IW-1:0]                   idx, ev_idx, hit_idx;
  logic                            ev, ev_vld;
  prq_pkg::cmd_t                   op;
  logic [prq_pkg::ID_W-1:0]        in_id, hit_id;
  logic [prq_pkg::PRIO_W-1:0]      in_prio, hit_prio;
  logic [prq_pkg::SLICE_W-1:0]     in_slice, hit_slice;
  logic                            hit;
  logic [CW-1:0]                   count, count_next;
  logic [prq_pkg::SLICE_W-1:0]     running, running_next, max_slice;
  prq_pkg::entry_t                 rd_entry, wr_entry;
  logic [EW-1:0]                   rd_bits;
  logic                            ram_we;
  logic                            found_next, resched_next;
  logic [prq_pkg::ID_W-1:0]        pid_next;
  logic [prq_pkg::PRIO_W-1:0]      ppri_next;
  logic [prq_pkg::SLICE_W-1:0]     gslice_next, tick_slice;
  prq_pkg::fault_t                 fault_next;
  logic                            take_pick;

  assign stat.idx_last = (idx == IW'(QUEUE_DEPTH - 1));

  assign wr_entry = '{id: in_id, prio: in_prio, slice: in_slice};
  assign ram_we   = ctl.commit && (op == prq_pkg::CMD_ENQUEUE) && hit;
  assign rd_entry = prq_pkg::entry_t'(rd_bits);

  prq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH),
    .AW    (IW)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hit_idx),
    .wdata (wr_entry),
    .raddr (idx),
    .rdata (rd_bits)
  );

  assign take_pick = ev_vld && (!hit || (rd_entry.prio > hit_prio) ||
                     ((rd_entry.prio == hit_prio) && (rd_entry.id < hit_id)));

  assign tick_slice = (running != '0) ? running - 8'd1 : running;

  always_comb begin
    found_next   = 1'b0;
    pid_next     = '0;
    ppri_next    = '0;
    gslice_next  = '0;
    resched_next = 1'b0;
    fault_next   = prq_pkg::FAULT_NONE;
    count_next   = count;
    running_next = running;
    case (op)
      prq_pkg::CMD_ENQUEUE: begin
        if (hit) begin
          gslice_next = in_slice;
          count_next  = count + CW'(1);
        end else begin
          fault_next = prq_pkg::FAULT_FULL;
        end
      end
      prq_pkg::CMD_DEQUEUE: begin
        if (hit) begin
          found_next   = 1'b1;
          gslice_next  = hit_slice;
          running_next = hit_slice;
          count_next   = count - CW'(1);
        end else begin
          fault_next = prq_pkg::FAULT_ABSENT;
        end
      end
      prq_pkg::CMD_PICK: begin
        if (hit) begin
          found_next = 1'b1;
          pid_next   = hit_id;
          ppri_next  = hit_prio;
        end
      end
      default: begin
        running_next = tick_slice;
        gslice_next  = tick_slice;
        resched_next = (tick_slice == '0);
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
      running    <= '0;
      max_slice  <= prq_pkg::MAX_SLICE_RESET;
      ev         <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_slice <= cfg_data;
      end
      ev   <= ctl.scan;
      done <= ctl.commit;
      if (ctl.commit) begin
        count   <= count_next;
        running <= running_next;
        if (hit && (op == prq_pkg::CMD_ENQUEUE)) begin
          slot_valid[hit_idx] <= 1'b1;
        end
        if (hit && (op == prq_pkg::CMD_DEQUEUE)) begin
          slot_valid[hit_idx] <= 1'b0;
        end
      end
    end
  end

  // scan and payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op      <= prq_pkg::cmd_t'(cmd);
      in_id   <= task_id;
      in_prio <= (task_priority == '0) ? prq_pkg::DEFAULT_PRIORITY : task_priority;
      in_slice <= ((task_slice == '0) || (task_slice > max_slice)) ? max_slice : task_slice;
      idx     <= '0;
      hit     <= 1'b0;
    end else begin
      if (ctl.scan) begin
        idx <= idx + IW'(1);
      end
      if (ev) begin
        case (op)
          prq_pkg::CMD_ENQUEUE: begin
            if (!hit && !ev_vld) begin
              hit     <= 1'b1;
              hit_idx <= ev_idx;
            end
          end
          prq_pkg::CMD_DEQUEUE: begin
            if (!hit && ev_vld && (rd_entry.id == in_id)) begin
              hit       <= 1'b1;
              hit_idx   <= ev_idx;
              hit_slice <= rd_entry.slice;
            end
          end
          prq_pkg::CMD_PICK: begin
            if (take_pick) begin
              hit      <= 1'b1;
              hit_id   <= rd_entry.id;
              hit_prio <= rd_entry.prio;
            end
          end
          default: begin
          end
        endcase
      end
    end
    ev_idx <= idx;
    ev_vld <= slot_valid[idx];
    if (ctl.commit) begin
      found           <= found_next;
      picked_id       <= pid_next;
      picked_priority <= ppri_next;
      granted_slice   <= gslice_next;
      resched         <= resched_next;
      queued_count    <= prq_pkg::COUNT_W'(count_next);
      fault           <= fault_next;
    end
  end

endmodule

[design/priority_run_queue.sv]
// channel   direction  beat marked by        payload
// command   in         start & !busy         cmd, task_id, task_priority, task_slice
// result    out        done (one cycle)      found, picked_id, picked_priority,
//                                            granted_slice, resched, queued_count, fault
// config    in         cfg_we                cfg_data (max_slice)
//
// enqueue, dequeue and pick scan every slot through the slot ram, one per
// cycle, then pass through the flush and done states before busy falls
// a tick skips the scan and flush and goes straight to done
// done pulses in the first cycle in which busy is low again; a new command may start then
// synchronous reset empties the queue, clears the running slice and sets
// max_slice to 5; the result side cannot stall
`include "priority_run_queue_macros.svh"

module priority_run_queue #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [prq_pkg::ID_W-1:0]      task_id,
  input  logic [prq_pkg::PRIO_W-1:0]    task_priority,
  input  logic [prq_pkg::SLICE_W-1:0]   task_slice,
  input  logic                          cfg_we,
  input  logic [prq_pkg::SLICE_W-1:0]   cfg_data,
  output logic                          done,
  output logic                          found,
  output logic [prq_pkg::ID_W-1:0]      picked_id,
  output logic [prq_pkg::PRIO_W-1:0]    picked_priority,
  output logic [prq_pkg::SLICE_W-1:0]   granted_slice,
  output logic                          resched,
  output logic [prq_pkg::COUNT_W-1:0]   queued_count,
  output logic [1:0]                    fault
);

  prq_pkg::ctrl_cmd_t  ctl;
  prq_pkg::ctrl_stat_t stat;

  prq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  prq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .cmd             (cmd),
    .task_id         (task_id),
    .task_priority   (task_priority),
    .task_slice      (task_slice),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .done            (done),
    .found           (found),
    .picked_id       (picked_id),
    .picked_priority (picked_priority),
    .granted_slice   (granted_slice),
    .resched         (resched),
    .queued_count    (queued_count),
    .fault           (fault)
  );

  `PRQ_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `PRQ_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `PRQ_ASSERT_IMP(a_fault_quiet, clk, rst, done && (fault != prq_pkg::FAULT_NONE),
                  !found && (granted_slice == '0))
  `PRQ_ASSERT_IMP(a_resched_zero, clk, rst, done && resched, granted_slice == '0)

endmodule
